/* rtl/rbq_pkg.sv */
// Shared types and constants of the resonant band-pass biquad.
`default_nettype none
package rbq_pkg;

  // Default widths of samples and coefficients.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int COEF_WIDTH_DEF   = 24;

  // Configuration register index width and register map.
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FORWARD_GAIN       = 2'd0,
    REG_RECURSIVE_GAIN_ONE = 2'd1,
    REG_RECURSIVE_GAIN_TWO = 2'd2,
    REG_RESONANCE_GAIN     = 2'd3
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB_ADD,
    ST_B0_MUL,
    ST_B2_MUL,
    ST_A1_MUL,
    ST_A2_MUL,
    ST_ACC_LAST,
    ST_WRITE
  } state_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_Y1_RES,
    MUL_XS_B0,
    MUL_X2_B0,
    MUL_Y1_A1,
    MUL_Y2_A2
  } mul_sel_t;

  // Accumulator operation on the rounded product.
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB
  } acc_op_t;

  // Command word from the controller to the datapath.
  typedef struct packed {
    mul_sel_t mul_sel;
    logic     load_in;
    logic     fb_update;
    acc_op_t  acc_op;
    logic     hist_update;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

/* rtl/rbq_if.sv */
// Channel interfaces: input samples, output samples and configuration writes.
`default_nettype none
interface rbq_in_if #(parameter int SAMPLE_WIDTH = rbq_pkg::SAMPLE_WIDTH_DEF);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface rbq_out_if #(parameter int SAMPLE_WIDTH = rbq_pkg::SAMPLE_WIDTH_DEF);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface rbq_cfg_if #(
  parameter int INDEX_W = rbq_pkg::CFG_INDEX_W,
  parameter int DATA_W  = rbq_pkg::COEF_WIDTH_DEF
);
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic [DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/rbq_ctrl.sv */
// Sequencer that steps the shared multiplier through one sample's products.
`default_nettype none
module rbq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              out_ready,
  output logic                   in_ready,
  output logic                   out_valid,
  output rbq_pkg::ctrl_cmd_t     cmd
);
  import rbq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   write_ok;

  // The result register can take a new sample once the old one is gone.
  assign write_ok = !(out_valid_r && !out_ready);

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_FB_ADD;
      ST_FB_ADD:   state_nxt = ST_B0_MUL;
      ST_B0_MUL:   state_nxt = ST_B2_MUL;
      ST_B2_MUL:   state_nxt = ST_A1_MUL;
      ST_A1_MUL:   state_nxt = ST_A2_MUL;
      ST_A2_MUL:   state_nxt = ST_ACC_LAST;
      ST_ACC_LAST: state_nxt = ST_WRITE;
      ST_WRITE:    if (write_ok) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd             = '0;
    cmd.mul_sel     = MUL_Y1_RES;
    cmd.acc_op      = ACC_HOLD;
    in_ready        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // The feedback product is kept fresh while waiting for a sample.
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_FB_ADD: begin
        cmd.fb_update = 1'b1;
      end
      ST_B0_MUL: begin
        cmd.mul_sel = MUL_XS_B0;
      end
      ST_B2_MUL: begin
        cmd.mul_sel = MUL_X2_B0;
        cmd.acc_op  = ACC_LOAD;
      end
      ST_A1_MUL: begin
        cmd.mul_sel = MUL_Y1_A1;
        cmd.acc_op  = ACC_SUB;
      end
      ST_A2_MUL: begin
        cmd.mul_sel = MUL_Y2_A2;
        cmd.acc_op  = ACC_SUB;
      end
      ST_ACC_LAST: begin
        cmd.acc_op = ACC_SUB;
      end
      ST_WRITE: begin
        cmd.hist_update = write_ok;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A written result raises valid; a taken one lowers it.
  always_comb begin
    if (cmd.hist_update) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/rbq_datapath.sv */
// Datapath: coefficient registers, history, shared multiplier and accumulator.
`default_nettype none
module rbq_datapath #(
  parameter int SAMPLE_WIDTH = rbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = rbq_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire rbq_pkg::ctrl_cmd_t               cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   sample_in,
  input  wire logic                             cfg_we,
  input  wire logic [rbq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [COEF_WIDTH-1:0]            cfg_data,
  output logic signed [SAMPLE_WIDTH-1:0]        sample_out
);
  import rbq_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_WIDTH;
  localparam int FS = CW - 2;        // fraction bits of the coefficients
  localparam int PW = SW + CW;       // full product width
  localparam int RW = SW + 3;        // rounded product width
  localparam int AW = SW + 6;        // accumulator width

  localparam logic signed [PW:0] RND_HALF = {{(PW + 1 - FS){1'b0}}, 1'b1, {(FS - 1){1'b0}}};
  localparam logic signed [RW-1:0] UNITY_R = {{(RW - SW + 3){1'b0}}, 1'b1, {(SW - 4){1'b0}}};
  localparam logic signed [RW-1:0] NUNITY_R = -UNITY_R;
  localparam logic signed [RW-1:0] SMAX_R = {{(RW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN_R = {{(RW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
  localparam logic signed [AW-1:0] SMAX_A = {{(AW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [AW-1:0] SMIN_A = {{(AW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};

  // Coefficient registers.
  logic signed [CW-1:0] b0_r, a1_r, a2_r;
  logic        [CW-2:0] res_r;

  // Filter history.
  logic signed [SW-1:0] x1_r, x2_r, y1_r, y2_r;

  // Working registers.
  logic signed [SW-1:0] x_in_r;
  logic signed [SW-1:0] xs_r;
  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [SW-1:0] out_sample_r;

  logic signed [SW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [PW:0]   prod_rnd;
  logic signed [RW-1:0] rounded;
  logic signed [RW-1:0] fb_clip;
  logic signed [RW-1:0] fb_sum;
  logic signed [SW-1:0] fb_sat;
  logic signed [AW-1:0] rounded_ext;
  logic signed [SW-1:0] y_sat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r  <= '0;
      a1_r  <= '0;
      a2_r  <= '0;
      res_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FORWARD_GAIN:       b0_r  <= cfg_data;
        REG_RECURSIVE_GAIN_ONE: a1_r  <= cfg_data;
        REG_RECURSIVE_GAIN_TWO: a2_r  <= cfg_data;
        REG_RESONANCE_GAIN:     res_r <= cfg_data[CW-2:0];
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.mul_sel)
      MUL_Y1_RES: begin
        mul_a = y1_r;
        mul_b = {1'b0, res_r};
      end
      MUL_XS_B0: begin
        mul_a = xs_r;
        mul_b = b0_r;
      end
      MUL_X2_B0: begin
        mul_a = x2_r;
        mul_b = b0_r;
      end
      MUL_Y1_A1: begin
        mul_a = y1_r;
        mul_b = a1_r;
      end
      MUL_Y2_A2: begin
        mul_a = y2_r;
        mul_b = a2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // Round half up to sample precision.
  assign prod_rnd = {prod_r[PW-1], prod_r} + RND_HALF;
  assign rounded  = prod_rnd[PW:FS];

  // Feedback is clipped to plus or minus one eighth of full scale, added, then saturated.
  always_comb begin
    if (rounded > UNITY_R) begin
      fb_clip = UNITY_R;
    end else if (rounded < NUNITY_R) begin
      fb_clip = NUNITY_R;
    end else begin
      fb_clip = rounded;
    end
    fb_sum = {{(RW - SW){x_in_r[SW-1]}}, x_in_r} + fb_clip;
    if (fb_sum > SMAX_R) begin
      fb_sat = SMAX_R[SW-1:0];
    end else if (fb_sum < SMIN_R) begin
      fb_sat = SMIN_R[SW-1:0];
    end else begin
      fb_sat = fb_sum[SW-1:0];
    end
  end

  // Output saturation of the accumulated sum.
  assign rounded_ext = {{(AW - RW){rounded[RW-1]}}, rounded};

  always_comb begin
    if (acc_r > SMAX_A) begin
      y_sat = SMAX_A[SW-1:0];
    end else if (acc_r < SMIN_A) begin
      y_sat = SMIN_A[SW-1:0];
    end else begin
      y_sat = acc_r[SW-1:0];
    end
  end

  // Sample capture, feedback sum and accumulator.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_in_r <= sample_in;
    end
    if (cmd.fb_update) begin
      xs_r <= fb_sat;
    end
    case (cmd.acc_op)
      ACC_LOAD: acc_r <= rounded_ext;
      ACC_SUB:  acc_r <= acc_r - rounded_ext;
      default:  acc_r <= acc_r;
    endcase
    if (cmd.hist_update) begin
      out_sample_r <= y_sat;
    end
  end

  // History shifts once per finished sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r <= '0;
      x2_r <= '0;
      y1_r <= '0;
      y2_r <= '0;
    end else if (cmd.hist_update) begin
      x2_r <= x1_r;
      x1_r <= xs_r;
      y2_r <= y1_r;
      y1_r <= y_sat;
    end
  end

  assign sample_out = out_sample_r;

endmodule
`default_nettype wire

/* rtl/resonant_bandpass_biquad_core.sv */
// Top level: resonant band-pass biquad with one shared multiplier.
// The result is written after the feedback sum and the five products that
// pass one after another through the single shared multiplier; a new sample
// is taken only once the last result is written, and a full result register stalls that write.
// Reset (synchronous, active low) clears coefficients, history and control.
`default_nettype none
module resonant_bandpass_biquad_core #(
  parameter int SAMPLE_WIDTH = rbq_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = rbq_pkg::COEF_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rbq_in_if.sink     in_stream,
  rbq_out_if.source  out_stream,
  rbq_cfg_if.sink    cfg_port
);
  import rbq_pkg::*;

  ctrl_cmd_t cmd;
  logic      in_ready;
  logic      out_valid;
  logic      cfg_we;

  // Configuration writes are always taken.
  assign cfg_port.ready = 1'b1;
  assign cfg_we         = cfg_port.valid;

  rbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .out_ready (out_stream.ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rbq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sample_in  (in_stream.sample_in),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_port.index),
    .cfg_data   (cfg_port.data),
    .sample_out (out_stream.sample_out)
  );

  assign in_stream.ready  = in_ready;
  assign out_stream.valid = out_valid;

`ifndef ASSERT_OFF
  // A new result is never written over one still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_update |-> !(out_valid && !out_stream.ready))
    else $error("result register overwritten while full");

  // After a transaction on the input the block is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stream.valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // The accumulator starts from the forward product of the fed-back sample.
  a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_op == ACC_LOAD) |-> ($past(cmd.mul_sel) == MUL_XS_B0))
    else $error("accumulator loaded from the wrong product");

  // A written result is offered on the next cycle.
  a_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_update |=> out_valid)
    else $error("result written but not offered");
`endif

endmodule
`default_nettype wire
